// ----- rtl/core/rprq_pkg.sv -----
// shared types, codes and constants of the real-time priority ready queue
package rprq_pkg;

    localparam int DEPTH_DEFAULT   = 32;
    localparam int TASK_ID_DEFAULT = 8;

    localparam logic [6:0]  PRIO_MIN      = 7'd1;
    localparam logic [6:0]  PRIO_MAX      = 7'd99;
    localparam logic [15:0] QUANTUM_RESET = 16'd10;
    localparam logic [15:0] QUANTUM_MIN   = 16'd1;

    localparam logic REQ_ENQUEUE  = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    localparam logic CFG_ROUND_ROBIN = 1'b0;
    localparam logic CFG_RR_QUANTUM  = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQUEUED   = 2'd0,
        ST_FULL       = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_EMPTY      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic       req_type;
        logic [7:0] task_id;
        logic [6:0] priority_req;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  dispatched_id;
        logic [15:0] time_slice_ms;
        logic [5:0]  queue_depth;
    } t_rsp;

    typedef struct packed {
        logic accept;
        logic clear_wr;
        logic scan_rd;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic addr_last;
        logic out_free;
    } t_dp_sts;

    function automatic logic [6:0] clamp_prio(input logic [6:0] p);
        logic [6:0] r;
        r = p;
        if (p < PRIO_MIN) r = PRIO_MIN;
        if (p > PRIO_MAX) r = PRIO_MAX;
        return r;
    endfunction

endpackage

// ----- rtl/core/rprq_ctrl.sv -----
// sequencer for clearing, slot scans and commits of the ready queue
module rprq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rprq_pkg::t_dp_sts i_sts,
    output rprq_pkg::t_dp_cmd o_cmd
);

    rprq_pkg::t_state r_state;
    rprq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rprq_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            rprq_pkg::S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.addr_last) n_state = rprq_pkg::S_IDLE;
            end
            rprq_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) n_state = rprq_pkg::S_SCAN;
            end
            rprq_pkg::S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.addr_last) n_state = rprq_pkg::S_LAST;
            end
            rprq_pkg::S_LAST: begin
                n_state = rprq_pkg::S_COMMIT;
            end
            rprq_pkg::S_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) n_state = rprq_pkg::S_IDLE;
            end
            default: begin
                n_state = rprq_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/core/rprq_dp.sv -----
// entry memory, scan compare, counters, configuration and result register
module rprq_dp #(
    parameter int QUEUE_DEPTH  = rprq_pkg::DEPTH_DEFAULT,
    parameter int TASK_ID_BITS = rprq_pkg::TASK_ID_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  rprq_pkg::t_req    i_in_data,
    input  rprq_pkg::t_dp_cmd i_cmd,
    output rprq_pkg::t_dp_sts o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rprq_pkg::t_rsp    o_out_data
);

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                    valid;
        logic [TASK_ID_BITS-1:0] task_id;
        logic [6:0]              prio;
        logic [15:0]             seq;
    } t_entry;

    t_entry r_mem [QUEUE_DEPTH];

    logic        r_round_robin;
    logic [15:0] r_quantum;

    logic [AW-1:0]    r_addr;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_idx;
    t_entry           r_rd_data;

    logic                    r_req_type;
    logic [TASK_ID_BITS-1:0] r_req_task;
    logic [6:0]              r_req_prio;

    logic          r_found;
    logic [AW-1:0] r_best_idx;
    t_entry        r_best;

    logic [15:0]      r_next_seq;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic           r_out_valid;
    rprq_pkg::t_rsp r_out;
    rprq_pkg::t_rsp n_out;

    logic          w_addr_last;
    logic [15:0]   w_seq_diff;
    logic          w_first;
    logic          w_take;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_entry        w_wdata;

    logic [TASK_ID_BITS+7:0] w_task_in_ext;
    logic [TASK_ID_BITS+7:0] w_task_out_ext;
    logic [CNT_W+5:0]        w_count_ext;

    assign w_addr_last     = (r_addr == AW'(QUEUE_DEPTH - 1));
    assign o_sts.addr_last = w_addr_last;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_robin <= 1'b0;
            r_quantum     <= rprq_pkg::QUANTUM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rprq_pkg::CFG_ROUND_ROBIN: r_round_robin <= i_cfg_data[0];
                rprq_pkg::CFG_RR_QUANTUM:  r_quantum     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // memory address sweep, shared by clearing and scanning
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.clear_wr || i_cmd.scan_rd) begin
                r_addr <= w_addr_last ? '0 : r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (i_cmd.scan_rd) begin
            r_rd_data <= r_mem[r_addr];
            r_rd_idx  <= r_addr;
        end
    end

    // request capture
    assign w_task_in_ext = {{TASK_ID_BITS{1'b0}}, i_in_data.task_id};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type <= i_in_data.req_type;
            r_req_task <= w_task_in_ext[TASK_ID_BITS-1:0];
            r_req_prio <= rprq_pkg::clamp_prio(i_in_data.priority_req);
        end
    end

    // scan compare: first free slot, or highest priority then oldest
    assign w_seq_diff = r_rd_data.seq - r_best.seq;
    assign w_first    = (r_rd_data.prio > r_best.prio) ||
                        ((r_rd_data.prio == r_best.prio) && w_seq_diff[15]);

    always_comb begin
        if (r_req_type == rprq_pkg::REQ_ENQUEUE) begin
            w_take = r_rd_vld && !r_found && !r_rd_data.valid;
        end else begin
            w_take = r_rd_vld && r_rd_data.valid && (!r_found || w_first);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.accept) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_idx <= r_rd_idx;
            r_best     <= r_rd_data;
        end
    end

    // memory write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = '0;
        if (i_cmd.clear_wr) begin
            w_we = 1'b1;
        end else if (i_cmd.commit && r_found) begin
            w_we    = 1'b1;
            w_waddr = r_best_idx;
            if (r_req_type == rprq_pkg::REQ_ENQUEUE) begin
                w_wdata.valid   = 1'b1;
                w_wdata.task_id = r_req_task;
                w_wdata.prio    = r_req_prio;
                w_wdata.seq     = r_next_seq;
            end else begin
                w_wdata       = r_best;
                w_wdata.valid = 1'b0;
            end
        end
    end

    // result
    assign w_task_out_ext = {8'd0, r_best.task_id};
    assign w_count_ext    = {6'd0, n_count};

    always_comb begin
        n_count = r_count;
        n_out   = '0;
        if (r_req_type == rprq_pkg::REQ_ENQUEUE) begin
            if (r_found) begin
                n_count      = r_count + 1'b1;
                n_out.status = rprq_pkg::ST_ENQUEUED;
            end else begin
                n_out.status = rprq_pkg::ST_FULL;
            end
        end else begin
            if (r_found) begin
                if (r_count != '0) n_count = r_count - 1'b1;
                n_out.status        = rprq_pkg::ST_DISPATCHED;
                n_out.dispatched_id = w_task_out_ext[7:0];
                if (r_round_robin) begin
                    n_out.time_slice_ms = (r_quantum == '0) ? rprq_pkg::QUANTUM_MIN
                                                            : r_quantum;
                end
            end else begin
                n_out.status = rprq_pkg::ST_EMPTY;
            end
        end
        n_out.queue_depth = w_count_ext[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_seq  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
                if (r_found && (r_req_type == rprq_pkg::REQ_ENQUEUE)) begin
                    r_next_seq <= r_next_seq + 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.accept, i_cmd.clear_wr, i_cmd.scan_rd, i_cmd.commit}))
        else $error("conflicting datapath commands");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_found && (r_req_type == rprq_pkg::REQ_ENQUEUE))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("entry count not advanced on enqueue");

    a_disp_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_found && (r_req_type == rprq_pkg::REQ_DISPATCH))
        |-> (r_count != '0))
        else $error("dispatch found an entry while count is zero");

endmodule

// ----- rtl/core/rt_priority_ready_queue_top.sv -----
// top level of the real-time priority ready queue
// flow: a request is taken in the idle state, then every slot is read in turn
// through the single read port of the entry memory, the last read is compared,
// and the result is committed to the result register; a new request is taken only
// after the commit, and a stalled result holds the commit and delays the next request
// reset: synchronous; afterwards a clearing pass writes every slot invalid,
// during which no request is taken (config writes are)
module rt_priority_ready_queue_top #(
    parameter int QUEUE_DEPTH  = rprq_pkg::DEPTH_DEFAULT,
    parameter int TASK_ID_BITS = rprq_pkg::TASK_ID_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rprq_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rprq_pkg::t_rsp o_out_data
);

    rprq_pkg::t_dp_cmd w_cmd;
    rprq_pkg::t_dp_sts w_sts;

    rprq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rprq_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
